// ----- design/u2ad_pkg.sv -----
// package for the unsigned to ascii digit converter
// shared types, constants and the digit to character mapping; no dependencies
`timescale 1ns / 1ps

package u2ad_pkg;

	localparam int NUM_CELLS = 16;
	localparam int DEC_BITS  = 32;
	localparam int VALUE_W   = 64;
	localparam int CHAR_W    = 8;
	localparam int SEL_W     = 2;
	localparam int NIB_W     = 4;

	localparam logic [SEL_W-1:0] REQ_DEC    = 2'd0;
	localparam logic [SEL_W-1:0] REQ_HEX_LO = 2'd1;
	localparam logic [SEL_W-1:0] REQ_HEX_UP = 2'd2;

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_DABBLE,
		OP_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} fsm_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [NIB_W-1:0] nib,
			input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
		if (nib < 4'd10) begin
			return ASCII_ZERO + {4'd0, nib};
		end else begin
			return base + {4'd0, nib} - 8'd10;
		end
	endfunction

endpackage

// ----- design/u2ad_cell.sv -----
// one digit cell of the converter row: holds or loads a nibble, shift-add-3 step or digit shift
// depends on u2ad_pkg
`timescale 1ns / 1ps

module u2ad_cell (
	input  logic                            clk,
	input  u2ad_pkg::cell_op_t              op,
	input  logic [u2ad_pkg::NIB_W-1:0]      load_nib,
	input  logic                            bit_in,
	input  logic [u2ad_pkg::NIB_W-1:0]      dig_in,
	output logic [u2ad_pkg::NIB_W-1:0]      digit,
	output logic                            carry
);

	logic [u2ad_pkg::NIB_W-1:0] digit_q;
	logic [u2ad_pkg::NIB_W-1:0] adj;

	// add 3 before doubling so the bcd digit carries at ten
	assign adj   = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry = adj[u2ad_pkg::NIB_W-1];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		case (op)
			u2ad_pkg::OP_LOAD:   digit_q <= load_nib;
			u2ad_pkg::OP_DABBLE: digit_q <= {adj[u2ad_pkg::NIB_W-2:0], bit_in};
			u2ad_pkg::OP_SHIFT:  digit_q <= dig_in;
			default:             digit_q <= digit_q;
		endcase
	end

endmodule

// ----- design/unsigned_to_ascii_digits.sv -----
// top level of the unsigned to ascii digit converter: sequencer and row of digit cells
// depends on u2ad_pkg and u2ad_cell
//
//  channel   dir  data                        side band
//  s_axis    in   tdata[63:0] value           tuser[1:0] req_type
//  m_axis    out  tdata[7:0]  digit_char      tlast last_digit
//
// hex: the value is loaded, then up to 15 leading zero nibbles are dropped before emitting
// starts, then one beat per digit; decimal first runs shift-add-3 steps over the low 32
// bits of the value through the cell row, one bit per cycle
// the next input beat is taken only once the last digit sits in the output register
// output stalls hold the cell row; req_type 3 is taken and produces no beats
// reset clears the sequencer and the output valid flag
`timescale 1ns / 1ps

module unsigned_to_ascii_digits (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [u2ad_pkg::VALUE_W-1:0]        s_tdata,   // [63:0] value
	input  logic [u2ad_pkg::SEL_W-1:0]          s_tuser,   // [1:0] req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [u2ad_pkg::CHAR_W-1:0]         m_tdata,   // [7:0] digit_char
	output logic                                m_tlast
);

	localparam int REMAIN_W = $clog2(u2ad_pkg::NUM_CELLS + 1);
	localparam int BITCNT_W = $clog2(u2ad_pkg::DEC_BITS);
	localparam int TOP      = u2ad_pkg::NUM_CELLS - 1;

	u2ad_pkg::fsm_t     state_q, state_d;
	u2ad_pkg::cell_op_t cell_op;

	logic [u2ad_pkg::DEC_BITS-1:0] bin_q;
	logic [BITCNT_W-1:0]           bit_cnt_q;
	logic [REMAIN_W-1:0]           remain_q;
	logic                          upper_q;
	logic [u2ad_pkg::CHAR_W-1:0]   out_data_q;
	logic                          out_last_q;
	logic                          out_valid_q;

	logic accept;
	logic dec_sel;
	logic dabble;
	logic shift_row;
	logic emit;
	logic slot_free;
	logic bcd_ok;

	logic [u2ad_pkg::NIB_W-1:0] digits [u2ad_pkg::NUM_CELLS];
	logic                       carries [u2ad_pkg::NUM_CELLS];

	assign dec_sel   = (s_tuser == u2ad_pkg::REQ_DEC);
	assign slot_free = !out_valid_q || m_tready;

	// row of digit cells, cell TOP holds the most significant digit
	genvar gi;
	generate
		for (gi = 0; gi < u2ad_pkg::NUM_CELLS; gi++) begin : g_cell
			logic [u2ad_pkg::NIB_W-1:0] nib_ld;
			logic [u2ad_pkg::NIB_W-1:0] nib_in;
			logic                       bit_nb;

			// decimal starts from an all-zero bcd row
			assign nib_ld = dec_sel ? '0 : s_tdata[gi*u2ad_pkg::NIB_W +: u2ad_pkg::NIB_W];

			if (gi == 0) begin : g_first
				assign nib_in = '0;
				assign bit_nb = bin_q[u2ad_pkg::DEC_BITS-1];
			end else begin : g_rest
				assign nib_in = digits[gi-1];
				assign bit_nb = carries[gi-1];
			end

			u2ad_cell u_cell (
				.clk      (clk),
				.op       (cell_op),
				.load_nib (nib_ld),
				.bit_in   (bit_nb),
				.dig_in   (nib_in),
				.digit    (digits[gi]),
				.carry    (carries[gi])
			);
		end
	endgenerate

	// sequencer
	always_comb begin
		state_d   = state_q;
		cell_op   = u2ad_pkg::OP_HOLD;
		s_tready  = 1'b0;
		accept    = 1'b0;
		dabble    = 1'b0;
		shift_row = 1'b0;
		emit      = 1'b0;
		case (state_q)
			u2ad_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == u2ad_pkg::REQ_DEC) begin
						accept  = 1'b1;
						cell_op = u2ad_pkg::OP_LOAD;
						state_d = u2ad_pkg::ST_CONV;
					end else if (s_tuser inside {u2ad_pkg::REQ_HEX_LO,
							u2ad_pkg::REQ_HEX_UP}) begin
						accept  = 1'b1;
						cell_op = u2ad_pkg::OP_LOAD;
						state_d = u2ad_pkg::ST_SKIP;
					end
					// unused selector: beat is consumed, nothing emitted
				end
			end
			u2ad_pkg::ST_CONV: begin
				dabble  = 1'b1;
				cell_op = u2ad_pkg::OP_DABBLE;
				if (bit_cnt_q == '0) begin
					state_d = u2ad_pkg::ST_SKIP;
				end
			end
			u2ad_pkg::ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (digits[TOP] == '0 && remain_q != REMAIN_W'(1)) begin
					shift_row = 1'b1;
					cell_op   = u2ad_pkg::OP_SHIFT;
				end else begin
					state_d = u2ad_pkg::ST_EMIT;
				end
			end
			u2ad_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					shift_row = 1'b1;
					cell_op   = u2ad_pkg::OP_SHIFT;
					if (remain_q == REMAIN_W'(1)) begin
						state_d = u2ad_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = u2ad_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= u2ad_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			remain_q    <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				bit_cnt_q <= BITCNT_W'(u2ad_pkg::DEC_BITS - 1);
				remain_q  <= REMAIN_W'(u2ad_pkg::NUM_CELLS);
			end else begin
				if (dabble) begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
				if (shift_row) begin
					remain_q <= remain_q - 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= s_tdata[u2ad_pkg::DEC_BITS-1:0];
			upper_q <= (s_tuser == u2ad_pkg::REQ_HEX_UP);
		end else if (dabble) begin
			bin_q <= {bin_q[u2ad_pkg::DEC_BITS-2:0], 1'b0};
		end
		if (emit) begin
			out_data_q <= u2ad_pkg::to_ascii(digits[TOP], upper_q);
			out_last_q <= (remain_q == REMAIN_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// every cell must hold a valid bcd digit while converting
	always_comb begin
		bcd_ok = 1'b1;
		for (int i = 0; i < u2ad_pkg::NUM_CELLS; i++) begin
			if (digits[i] > 4'd9) begin
				bcd_ok = 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2ad_pkg::ST_CONV) |-> bcd_ok)
		else $error("cell row left bcd range during conversion");

	a_remain_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2ad_pkg::ST_SKIP || state_q == u2ad_pkg::ST_EMIT)
			|-> (remain_q != '0))
		else $error("digit count ran out before the last beat");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2ad_pkg::ST_EMIT && slot_free && remain_q == REMAIN_W'(1))
			|=> (state_q == u2ad_pkg::ST_IDLE && m_tvalid && m_tlast))
		else $error("final digit not flagged or sequencer not back in idle");

	a_mid_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2ad_pkg::ST_EMIT && slot_free && remain_q != REMAIN_W'(1))
			|=> (m_tvalid && !m_tlast))
		else $error("last flag set on an inner digit");
`endif

endmodule
